// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bld_pkg.sv
`timescale 1ns / 1ps
package bld_pkg;

  // Internal fraction bits of the table values.
  localparam int unsigned WQ        = 30;
  // Tables cover |theta| in [0, TAB_RANGE].
  localparam int unsigned TAB_RANGE = 16;

  // Load enables of the interpolation stages.
  typedef struct packed {
    logic rd;
    logic mul;
    logic sub;
  } bld_stg_t;

endpackage

// File: rtl/bld_if.sv
`timescale 1ns / 1ps
interface bld_in_if;
  logic        valid;
  logic        ready;
  logic        observation;
  logic [23:0] natural_param;
  logic        want_first;
  logic        want_second;

  modport source (output valid, output observation, output natural_param,
                  output want_first, output want_second, input ready);
  modport sink   (input valid, input observation, input natural_param,
                  input want_first, input want_second, output ready);
endinterface

interface bld_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] log_likelihood;
  logic [17:0] first_deriv;
  logic [14:0] second_deriv;
  logic        first_valid;
  logic        second_valid;

  modport source (output valid, output log_likelihood, output first_deriv,
                  output second_deriv, output first_valid, output second_valid,
                  input ready);
  modport sink   (input valid, input log_likelihood, input first_deriv,
                  input second_deriv, input first_valid, input second_valid,
                  output ready);
endinterface

// File: rtl/bld_interp.sv
`timescale 1ns / 1ps
module bld_interp import bld_pkg::*; #(
  parameter int unsigned FRAC_BITS          = 16,
  parameter int unsigned APPROX_TABLE_DEPTH = 256,
  parameter bit          IS_LOG             = 1'b0,
  localparam int unsigned IW = $clog2(APPROX_TABLE_DEPTH + 1),
  localparam int unsigned RW = FRAC_BITS + 4
) (
  input  logic          clk_i,
  input  bld_stg_t      en_i,
  input  logic [IW-1:0] idx_i,
  input  logic          sat_i,
  input  logic [RW-1:0] rem_i,
  output logic [30:0]   val_o
);

  typedef logic [30:0] tab_t [0:APPROX_TABLE_DEPTH];

  // Shift-subtract quotient, evaluated only while the tables are built.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned quo;
    longint unsigned part;
    quo  = 0;
    part = 0;
    for (int b = 63; b >= 0; b--) begin
      part = (part << 1) | ((num >> b) & 64'd1);
      quo  = quo << 1;
      if (part >= den) begin
        part = part - den;
        quo  = quo | 64'd1;
      end
    end
    return quo;
  endfunction

  // Builds c(t) = e^-t/(1+e^-t) or g(t) = ln(1+e^-t) at the grid points.
  function automatic tab_t build_tab(input bit log_tab);
    tab_t                tab;
    longint unsigned     one;
    longint unsigned     step;
    longint unsigned     term;
    longint              sum;
    longint unsigned     u;
    longint unsigned     eq;
    longint unsigned     z;
    longint unsigned     z2;
    longint unsigned     pw;
    longint unsigned     acc;
    one  = 64'd1 << WQ;
    step = udiv(64'(TAB_RANGE) << WQ, 64'(APPROX_TABLE_DEPTH));
    term = one;
    sum  = longint'(one);
    u    = one;
    for (int k = 1; k <= 24; k++) begin
      term = udiv((term * step) >> WQ, 64'(k));
      if (k[0]) sum = sum - longint'(term);
      else      sum = sum + longint'(term);
    end
    eq = longint'(sum);
    for (int i = 0; i <= int'(APPROX_TABLE_DEPTH); i++) begin
      z   = udiv(u << WQ, 2 * one + u);
      z2  = (z * z) >> WQ;
      pw  = z;
      acc = 0;
      for (int k = 0; k < 20; k++) begin
        acc = acc + udiv(pw, 64'(2 * k + 1));
        pw  = (pw * z2) >> WQ;
      end
      if (log_tab) tab[i] = 31'(2 * acc);
      else         tab[i] = 31'(udiv(u << WQ, one + u));
      u = (u * eq + (one >> 1)) >> WQ;
    end
    return tab;
  endfunction

  localparam tab_t TAB = build_tab(IS_LOG);

  logic [IW-1:0]    nxt;
  logic [30:0]      lo_q, hi_q, lo2_q, diff;
  logic [RW-1:0]    rem_q;
  logic [31+RW-1:0] prod_q;
  logic [30:0]      val_q;

  assign nxt = sat_i ? idx_i : idx_i + IW'(1);

  always_ff @(posedge clk_i) begin
    if (en_i.rd) begin
      lo_q  <= TAB[idx_i];
      hi_q  <= TAB[nxt];
      rem_q <= rem_i;
    end
  end

  assign diff = (lo_q >= hi_q) ? lo_q - hi_q : 31'd0;

  always_ff @(posedge clk_i) begin
    if (en_i.mul) begin
      prod_q <= (31+RW)'(diff) * (31+RW)'(rem_q);
      lo2_q  <= lo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.sub) begin
      val_q <= lo2_q - 31'(prod_q >> RW);
    end
  end

  assign val_o = val_q;

endmodule

// File: rtl/bernoulli_loglik_derivatives.sv
`timescale 1ns / 1ps
// Bernoulli log-likelihood, score and curvature in fixed point.
// Throughput: one beat per cycle while out_o.ready is high; each stage holds
// only when it is full and the next stage is stalled (seven register stages).
// Reset: rst_ni clears all stage valid bits; payload registers are not reset.
module bernoulli_loglik_derivatives import bld_pkg::*; #(
  parameter int unsigned FRAC_BITS          = 16,
  parameter int unsigned APPROX_TABLE_DEPTH = 256
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bld_in_if.sink    in_i,
  bld_out_if.source out_o
);

`include "assert_macros.svh"

  localparam int unsigned IW  = $clog2(APPROX_TABLE_DEPTH + 1);
  localparam int unsigned RW  = FRAC_BITS + 4;   // span = 16 << FRAC_BITS
  localparam int unsigned PW  = 24 + IW;         // |theta| * depth
  localparam int unsigned NS  = 7;               // pipeline stages
  localparam int unsigned SH  = WQ - FRAC_BITS;  // Q30 -> output shift

  // Side info that rides along with each beat.
  typedef struct packed {
    logic        a;
    logic [23:0] theta;
    logic        w1;
    logic        w2;
  } side_t;

  // ---------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor moves.
  // ---------------------------------------------------------------------
  logic [NS:1] v_q;
  logic [NS+1:1] en;

  always_comb begin
    en[NS+1] = out_o.ready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_i.valid;
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Side info for stages 1..5.
  side_t side_q [1:5];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      side_q[1] <= '{a: in_i.observation, theta: in_i.natural_param,
                     w1: in_i.want_first, w2: in_i.want_second};
    end
    for (int k = 2; k <= 5; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: magnitude of theta.
  // ---------------------------------------------------------------------
  logic [23:0] t_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      t_q <= in_i.natural_param[23] ? 24'(-in_i.natural_param) : in_i.natural_param;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: grid position; index is a shift, remainder a mask.
  // ---------------------------------------------------------------------
  logic [PW-1:0] pos;
  logic [PW-1:0] idx_full;
  logic          sat;
  logic [IW-1:0] idx_q;
  logic          sat_q;
  logic [RW-1:0] rem_q;

  assign pos      = PW'(t_q) * PW'(APPROX_TABLE_DEPTH);
  assign idx_full = pos >> RW;
  assign sat      = idx_full >= PW'(APPROX_TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sat_q <= sat;
      idx_q <= sat ? IW'(APPROX_TABLE_DEPTH) : idx_full[IW-1:0];
      rem_q <= pos[RW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Stages 3..5: table read, slope multiply, subtract (both tables).
  // ---------------------------------------------------------------------
  bld_stg_t    stg;
  logic [30:0] c_val, g_val;

  assign stg = '{rd: en[3], mul: en[4], sub: en[5]};

  bld_interp #(
    .FRAC_BITS(FRAC_BITS), .APPROX_TABLE_DEPTH(APPROX_TABLE_DEPTH), .IS_LOG(1'b0)
  ) u_comp (
    .clk_i(clk_i), .en_i(stg), .idx_i(idx_q), .sat_i(sat_q), .rem_i(rem_q),
    .val_o(c_val)
  );

  bld_interp #(
    .FRAC_BITS(FRAC_BITS), .APPROX_TABLE_DEPTH(APPROX_TABLE_DEPTH), .IS_LOG(1'b1)
  ) u_lg (
    .clk_i(clk_i), .en_i(stg), .idx_i(idx_q), .sat_i(sat_q), .rem_i(rem_q),
    .val_o(g_val)
  );

  // ---------------------------------------------------------------------
  // Stage 6: sigmoid, log-likelihood, score, and c*(1-c) product.
  // ---------------------------------------------------------------------
  localparam logic [30:0] ONE_Q = 31'(64'd1 << WQ);
  localparam logic [30:0] HALF_LSB = 31'(64'd1 << (SH - 1));

  side_t        s6;
  logic [30:0]  s_val, one_m_c;
  logic [31:0]  s_out, g_out;
  logic signed [26:0] th, ll, ll_sat;
  logic signed [26:0] d1;
  logic [23:0]  ll_q;
  logic [17:0]  d1_q;
  logic [61:0]  pr_q;
  logic         w1_q, w2_q;

  assign s6      = side_q[5];
  assign one_m_c = ONE_Q - c_val;
  assign s_val   = s6.theta[23] ? c_val : one_m_c;
  assign s_out   = (32'(s_val) + 32'(HALF_LSB)) >> SH;
  assign g_out   = (32'(g_val) + 32'(HALF_LSB)) >> SH;
  assign th      = 27'(signed'(s6.theta));

  always_comb begin
    if (s6.a) ll = (th[26] ? th : 27'sd0) - signed'(27'(g_out));
    else      ll = -(th[26] ? 27'sd0 : th) - signed'(27'(g_out));
    ll_sat = (ll < -27'sd8388608) ? -27'sd8388608 : ll;
    d1     = signed'(27'(s6.a) << FRAC_BITS) - signed'(27'(s_out));
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      ll_q <= ll_sat[23:0];
      d1_q <= s6.w1 ? d1[17:0] : 18'd0;
      pr_q <= 62'(c_val) * 62'(one_m_c);
      w1_q <= s6.w1;
      w2_q <= s6.w2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: curvature rounding and output register.
  // ---------------------------------------------------------------------
  logic [31:0] pr_out;
  logic [23:0] o_ll_q;
  logic [17:0] o_d1_q;
  logic [14:0] o_d2_q;
  logic        o_w1_q, o_w2_q;

  assign pr_out = (32'(pr_q >> WQ) + 32'(HALF_LSB)) >> SH;

  always_ff @(posedge clk_i) begin
    if (en[7]) begin
      o_ll_q <= ll_q;
      o_d1_q <= d1_q;
      o_d2_q <= w2_q ? 15'(-pr_out) : 15'd0;
      o_w1_q <= w1_q;
      o_w2_q <= w2_q;
    end
  end

  assign out_o.valid          = v_q[NS];
  assign out_o.log_likelihood = o_ll_q;
  assign out_o.first_deriv    = o_d1_q;
  assign out_o.second_deriv   = o_d2_q;
  assign out_o.first_valid    = o_w1_q;
  assign out_o.second_valid   = o_w2_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `ASSERT_IMP(a_stall_full, clk_i, rst_ni, !in_i.ready, (&v_q) && !out_o.ready, "back-pressure with a bubble in the pipe")
  `ASSERT_IMP(a_d1_gate, clk_i, rst_ni, out_o.valid && !out_o.first_valid, out_o.first_deriv == 18'd0, "ungated first derivative")
  `ASSERT_IMP(a_d2_sign, clk_i, rst_ni, out_o.valid, out_o.second_deriv[14] || out_o.second_deriv == 15'd0, "positive second derivative")
  `ASSERT_NXT(a_fill, clk_i, rst_ni, in_i.valid && in_i.ready, v_q[1], "accepted beat not captured")

endmodule

// File: tb/bld_tb_if.sv
`timescale 1ns / 1ps
// Carriers for one input beat as queued by the stimulus and for one expected result.
package bld_tb_pkg;

  typedef struct packed {
    logic        observation;
    logic [23:0] natural_param;
    logic        want_first;
    logic        want_second;
  } bld_req_t;

  typedef struct packed {
    logic [23:0] log_likelihood;
    logic [17:0] first_deriv;
    logic [14:0] second_deriv;
    logic        first_valid;
    logic        second_valid;
  } bld_res_t;

endpackage

// File: tb/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import bld_tb_pkg::*;

  localparam int FRAC       = 16;
  localparam int DEPTH      = 256;
  localparam int QW         = 30;
  localparam int RANGE      = 16;
  localparam int LATENCY    = 7;
  localparam int NUM_RANDOM = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  bld_in_if  in_bus();
  bld_out_if out_bus();

  bernoulli_loglik_derivatives u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Q30 tables of c(t) = 1 - sigmoid(t) and g(t) = ln(1 + e^-t)
  longint unsigned comp_q30[DEPTH+1];
  longint unsigned logexp_q30[DEPTH+1];

  bld_req_t pending_beats[$];
  bld_res_t expected_beats[$];
  int       err_count;
  bit       stim_done;
  int       hold_off;   // cycles left in a forced long receiver stall

  // e^-step by Taylor series, then powers of it; c by division, g by atanh series
  task automatic build_tables();
    longint unsigned one, stepq, term, eq, u, z, z2, pw, acc;
    longint signed   sum;
    one   = 64'd1 << QW;
    stepq = (longint'(RANGE) << QW) / DEPTH;
    term  = one;
    sum   = one;
    u     = one;
    for (int k = 1; k <= 24; k++) begin
      term = ((term * stepq) >> QW) / k;
      if (k & 1) sum -= term; else sum += term;
    end
    eq = sum;
    for (int i = 0; i <= DEPTH; i++) begin
      z  = (u << QW) / (2 * one + u);
      z2 = (z * z) >> QW;
      pw = z;
      acc = 0;
      comp_q30[i] = (u << QW) / (one + u);
      for (int k = 0; k < 20; k++) begin
        acc += pw / (2 * k + 1);
        pw = (pw * z2) >> QW;
      end
      logexp_q30[i] = 2 * acc;
      u = (u * eq + (one >> 1)) >> QW;
    end
  endtask

  function automatic longint unsigned interp(bit use_log, longint unsigned mag);
    longint unsigned span, p, idx, rem, lo, hi, d;
    span = longint'(RANGE) << FRAC;
    p    = mag * DEPTH;
    idx  = p / span;
    rem  = p % span;
    if (idx >= DEPTH) return use_log ? logexp_q30[DEPTH] : comp_q30[DEPTH];
    lo = use_log ? logexp_q30[idx] : comp_q30[idx];
    hi = use_log ? logexp_q30[idx+1] : comp_q30[idx+1];
    d  = (lo >= hi) ? lo - hi : 0;
    return lo - (d * rem) / span;
  endfunction

  // Q30 to Q.FRAC, round half up
  function automatic longint signed q30_round(longint unsigned v);
    return longint'((v + (64'd1 << (QW - FRAC - 1))) >> (QW - FRAC));
  endfunction

  function automatic bld_res_t predict_loglik(bld_req_t req);
    bld_res_t        res;
    longint signed   theta, ll, d1, d2;
    longint unsigned mag, c, g, s, one;
    one   = 64'd1 << QW;
    theta = longint'($signed(req.natural_param));
    mag   = (theta < 0) ? -theta : theta;
    c     = interp(1'b0, mag);
    g     = interp(1'b1, mag);
    s     = (theta >= 0) ? one - c : c;
    if (req.observation) ll = ((theta < 0) ? theta : 0) - q30_round(g);
    else ll = -((theta > 0) ? theta : 0) - q30_round(g);
    if (ll < -64'sh800000) ll = -64'sh800000;   // saturate at the bottom of Q8.16
    d1 = 0;
    d2 = 0;
    if (req.want_first) d1 = (longint'(req.observation) << FRAC) - q30_round(s);
    if (req.want_second) d2 = -q30_round((c * (one - c)) >> QW);
    res.log_likelihood = ll[23:0];
    res.first_deriv    = d1[17:0];
    res.second_deriv   = d2[14:0];
    res.first_valid    = req.want_first;
    res.second_valid   = req.want_second;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_count++;
  endtask

  // idle pattern: random ~22% except in a quiet window
  function automatic bit idle_now(int cyc);
    if (cyc > 1000 && cyc < 1400) return 1'b0;
    return $urandom_range(99) < 22;
  endfunction

  int cyc;
  always @(posedge clk_i) cyc <= cyc + 1;

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_bus.valid         <= 1'b0;
      in_bus.observation   <= 1'b0;
      in_bus.natural_param <= '0;
      in_bus.want_first    <= 1'b0;
      in_bus.want_second   <= 1'b0;
    end else if (!in_bus.valid || in_bus.ready) begin
      // previous beat, if any, went through this edge: compute what it produces
      if (in_bus.valid)
        expected_beats.push_back(predict_loglik({in_bus.observation,
            in_bus.natural_param, in_bus.want_first, in_bus.want_second}));
      if (pending_beats.size() != 0 && !idle_now(cyc)) begin
        bld_req_t nxt;
        nxt = pending_beats.pop_front();
        in_bus.valid         <= 1'b1;
        in_bus.observation   <= nxt.observation;
        in_bus.natural_param <= nxt.natural_param;
        in_bus.want_first    <= nxt.want_first;
        in_bus.want_second   <= nxt.want_second;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // long receiver stall counter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_off <= 0;
    end else if (cyc == 600) begin
      hold_off <= 60;
    end else if (hold_off != 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected beat", out_bus.log_likelihood, 0);
        end else begin
          bld_res_t exp_res;
          exp_res = expected_beats.pop_front();
          if (out_bus.log_likelihood !== exp_res.log_likelihood)
            report_mismatch("log_likelihood", out_bus.log_likelihood,
                            exp_res.log_likelihood);
          if (out_bus.first_deriv !== exp_res.first_deriv)
            report_mismatch("first_deriv", out_bus.first_deriv, exp_res.first_deriv);
          if (out_bus.second_deriv !== exp_res.second_deriv)
            report_mismatch("second_deriv", out_bus.second_deriv, exp_res.second_deriv);
          if (out_bus.first_valid !== exp_res.first_valid)
            report_mismatch("first_valid", out_bus.first_valid, exp_res.first_valid);
          if (out_bus.second_valid !== exp_res.second_valid)
            report_mismatch("second_valid", out_bus.second_valid, exp_res.second_valid);
        end
      end
      // one long hold-off early in the random part fills the pipeline
      out_bus.ready <= (hold_off > 1 || cyc == 600) ? 1'b0 : !idle_now(cyc);
    end
  end

  function automatic bld_req_t make_req(bit a, logic [23:0] th, bit w1, bit w2);
    bld_req_t r;
    r.observation   = a;
    r.natural_param = th;
    r.want_first    = w1;
    r.want_second   = w2;
    return r;
  endfunction

  initial begin
    logic [23:0] th;
    int          sel;
    err_count = 0;
    stim_done = 1'b0;
    build_tables();

    // directed: zero, extremes, saturation at |theta| >= 16, table knots, flags
    pending_beats.push_back(make_req(1'b0, 24'h000000, 1'b1, 1'b1));
    pending_beats.push_back(make_req(1'b1, 24'h000000, 1'b1, 1'b1));
    pending_beats.push_back(make_req(1'b0, 24'h7FFFFF, 1'b1, 1'b1)); // ll just above the bottom
    pending_beats.push_back(make_req(1'b1, 24'h7FFFFF, 1'b1, 1'b1));
    pending_beats.push_back(make_req(1'b0, 24'h800000, 1'b1, 1'b1));
    pending_beats.push_back(make_req(1'b1, 24'h800000, 1'b1, 1'b1)); // ll at the bottom
    pending_beats.push_back(make_req(1'b1, 24'h100000, 1'b1, 1'b1)); // theta = 16
    pending_beats.push_back(make_req(1'b0, 24'hF00000, 1'b1, 1'b1)); // theta = -16
    pending_beats.push_back(make_req(1'b1, 24'h0FFFFF, 1'b1, 1'b1));
    pending_beats.push_back(make_req(1'b0, 24'hF00001, 1'b1, 1'b1));
    pending_beats.push_back(make_req(1'b1, 24'h001000, 1'b0, 1'b0)); // one knot
    pending_beats.push_back(make_req(1'b0, 24'h000FFF, 1'b1, 1'b0));
    pending_beats.push_back(make_req(1'b1, 24'hFFFFFF, 1'b0, 1'b1));
    pending_beats.push_back(make_req(1'b0, 24'h000001, 1'b0, 1'b0));
    pending_beats.push_back(make_req(1'b1, 24'hFF8000, 1'b1, 1'b0));
    pending_beats.push_back(make_req(1'b0, 24'h020000, 1'b0, 1'b1));

    // random: mostly |theta| < 16 where tables interpolate, rest full range
    for (int n = 0; n < NUM_RANDOM; n++) begin
      sel = $urandom_range(9);
      if (sel < 6) th = $urandom_range(24'h1FFFFF) - 24'h100000;
      else if (sel < 8) th = $urandom_range(24'h3FFF) - 24'h2000;
      else th = $urandom;
      pending_beats.push_back(make_req($urandom_range(1), th, $urandom_range(1),
                                       $urandom_range(1)));
    end

    #1 ;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_beats.size() == 0);
    @(posedge clk_i);
    while (in_bus.valid) @(posedge clk_i);
    wait (expected_beats.size() == 0);
    repeat (LATENCY * 4) @(posedge clk_i);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule

// File: bernoulli_loglik_derivatives.f
+incdir+rtl
rtl/bld_pkg.sv
rtl/bld_if.sv
rtl/bld_interp.sv
rtl/bernoulli_loglik_derivatives.sv
tb/bld_tb_if.sv
tb/testbench.sv
